// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cu_pkg.sv
// Shared types, constants and the binomial table builder of the combination unranker.
package cu_pkg;

    // Field and register widths.
    localparam int RANK_W      = 33;
    localparam int POS_W       = 6;
    localparam int SET_SIZE_W  = 7;
    localparam int CHOOSE_W    = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // Table entries are saturated just above the largest rank.
    localparam int ENTRY_W = RANK_W + 1;
    localparam logic [ENTRY_W-1:0] ENTRY_SAT = ENTRY_W'(1) << RANK_W;

    // Parameter defaults and limits.
    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int DEF_MAX_CHOOSE   = 8;
    localparam int CHOOSE_LIMIT     = 16;

    // Register reset values.
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RESET = SET_SIZE_W'(52);
    localparam logic [CHOOSE_W-1:0]   CHOOSE_RESET   = CHOOSE_W'(2);

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SET_SIZE     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CHOOSE_COUNT = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_WALK
    } cu_state_t;

    typedef struct packed {
        logic [SET_SIZE_W-1:0] set_size;
        logic [CHOOSE_W-1:0]   choose_count;
    } cu_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last;
        logic             out_of_range;
    } cu_result_t;

    // Saturated C(n,k), built row by row with Pascal's rule at elaboration.
    function automatic logic [ENTRY_W-1:0] binom_sat(input int n, input int k);
        logic [ENTRY_W-1:0] row [CHOOSE_LIMIT+1];
        logic [ENTRY_W:0]   sum;
        for (int j = 0; j <= CHOOSE_LIMIT; j++) begin
            row[j] = (j == 0) ? ENTRY_W'(1) : '0;
        end
        for (int r = 1; r <= n; r++) begin
            for (int j = CHOOSE_LIMIT; j >= 1; j--) begin
                sum    = {1'b0, row[j]} + {1'b0, row[j-1]};
                row[j] = (sum >= {1'b0, ENTRY_SAT}) ? ENTRY_SAT : sum[ENTRY_W-1:0];
            end
        end
        if (k < 0 || k > CHOOSE_LIMIT) begin
            return '0;
        end
        return row[k];
    endfunction

endpackage

// File: rtl/cu_binom_rom.sv
// Binomial coefficient ROM with a registered read port.
module cu_binom_rom #(
    parameter int MAX_ELEMENTS = cu_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_CHOOSE   = cu_pkg::DEF_MAX_CHOOSE,
    parameter int ADDR_W       = 11
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [cu_pkg::ENTRY_W-1:0] rd_data
);

    localparam int NW    = $clog2(MAX_ELEMENTS + 1);
    localparam int KW    = ADDR_W - NW;
    localparam int DEPTH = 1 << ADDR_W;

    logic [cu_pkg::ENTRY_W-1:0] rom [DEPTH];
    logic [cu_pkg::ENTRY_W-1:0] rd_data_reg;

    // Contents: address is {n, k}; entries outside the table read as zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam int N = i >> KW;
        localparam int K = i & ((1 << KW) - 1);
        assign rom[i] = (N <= MAX_ELEMENTS && K <= MAX_CHOOSE) ?
                        cu_pkg::binom_sat(N, K) : '0;
    end

    // Synchronous read; the word holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cu_walker.sv
// Sequencer that walks the set, one table lookup per element.
module cu_walker #(
    parameter int MAX_ELEMENTS = cu_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_CHOOSE   = cu_pkg::DEF_MAX_CHOOSE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cu_pkg::cu_cfg_t           cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [cu_pkg::RANK_W-1:0] rank,
    input  logic                      step_en,
    output logic                      push,
    output cu_pkg::cu_result_t        result
);

    localparam int NW     = $clog2(MAX_ELEMENTS + 1);
    localparam int KW     = $clog2(MAX_CHOOSE + 1);
    localparam int PW     = $clog2(MAX_ELEMENTS);
    localparam int ADDR_W = NW + KW;

    cu_pkg::cu_state_t state_reg, state_next;

    logic [cu_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic [NW-1:0]              n_reg, n_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [NW-1:0]              e_reg, e_next;
    logic [KW-1:0]              rc_reg, rc_next;
    logic [PW-1:0]              p_reg, p_next;

    logic [NW-1:0]              n_sat;
    logic [KW-1:0]              k_sat;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [cu_pkg::ENTRY_W-1:0] rd_data;
    logic                       take;
    logic                       reject;
    logic                       final_take;
    logic [KW-1:0]              rc_step;

    // Registers above their limits saturate.
    assign n_sat = (int'(cfg.set_size) > MAX_ELEMENTS) ? NW'(MAX_ELEMENTS)
                                                       : NW'(cfg.set_size);
    assign k_sat = (int'(cfg.choose_count) > MAX_CHOOSE) ? KW'(MAX_CHOOSE)
                                                         : KW'(cfg.choose_count);

    cu_binom_rom #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_CHOOSE   (MAX_CHOOSE),
        .ADDR_W       (ADDR_W)
    ) u_rom (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // One compare serves both the total check and the per-element test.
    assign take       = {1'b0, rank_reg} >= rd_data;
    assign reject     = (k_reg == '0) || take;
    assign final_take = take && (rc_reg == KW'(1));
    assign rc_step    = take ? rc_reg - KW'(1) : rc_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cu_pkg::ST_TOTAL;
                end
            end
            cu_pkg::ST_TOTAL:
            begin
                if (step_en)
                begin
                    state_next = reject ? cu_pkg::ST_IDLE : cu_pkg::ST_WALK;
                end
            end
            cu_pkg::ST_WALK:
            begin
                if (step_en && final_take)
                begin
                    state_next = cu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cu_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake, table read and result word.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = {n_sat, k_sat};
        push     = 1'b0;
        result   = '{position: '0, last: 1'b1, out_of_range: 1'b1};
        unique case (state_reg)
            cu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            cu_pkg::ST_TOTAL:
            begin
                if (step_en)
                begin
                    if (reject)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = {n_reg - NW'(1), k_reg};
                    end
                end
            end
            cu_pkg::ST_WALK:
            begin
                if (step_en)
                begin
                    rd_en   = 1'b1;
                    rd_addr = {e_reg - NW'(1), rc_step};
                    push    = take;
                    result  = '{position: cu_pkg::POS_W'(p_reg),
                                last: rc_reg == KW'(1),
                                out_of_range: 1'b0};
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        rank_next = rank_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        e_next    = e_reg;
        rc_next   = rc_reg;
        p_next    = p_reg;
        case (state_reg)
            cu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rank_next = rank;
                    n_next    = n_sat;
                    k_next    = k_sat;
                end
            end
            cu_pkg::ST_TOTAL:
            begin
                if (step_en && !reject)
                begin
                    e_next  = n_reg - NW'(1);
                    rc_next = k_reg;
                    p_next  = '0;
                end
            end
            cu_pkg::ST_WALK:
            begin
                if (step_en)
                begin
                    if (take)
                    begin
                        rank_next = rank_reg - rd_data[cu_pkg::RANK_W-1:0];
                    end
                    rc_next = rc_step;
                    e_next  = e_reg - NW'(1);
                    p_next  = p_reg + PW'(1);
                end
            end
            default:
            begin
                rank_next = rank_reg;
            end
        endcase
    end

    // State and walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cu_pkg::ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            e_reg     <= '0;
            rc_reg    <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            e_reg     <= e_next;
            rc_reg    <= rc_next;
            p_reg     <= p_next;
        end
    end

    // The remaining rank is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
    end

endmodule

// File: rtl/combination_unranker.sv
// Top level of the combination unranker: configuration, walker and output register.
//
// Takes a rank and returns, one word per chosen element, the ascending positions of
// the combination of choose_count out of set_size that the rank names; the final word
// carries last. A rank at or above C(set_size, choose_count), or a choose count of
// zero, gives a single word with out_of_range and last set and position zero.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Values above
// MAX_ELEMENTS or MAX_CHOOSE saturate. One rank is handled at a time. A rank is accepted
// while the total count is read, the total is then compared with the rank, and the walk
// then visits the set elements up to and including the last chosen one, with one ROM
// read per element; an out-of-range rank ends at the compare. The binomial ROM has a
// single read port. A full output register that is not taken holds the walk in place.
module combination_unranker #(
    parameter int MAX_ELEMENTS = cu_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_CHOOSE   = cu_pkg::DEF_MAX_CHOOSE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cu_pkg::RANK_W-1:0]      rank,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cu_pkg::POS_W-1:0]       position,
    output logic                           last,
    output logic                           out_of_range
);

`include "assert_macros.svh"

    logic [cu_pkg::SET_SIZE_W-1:0] set_size_reg, set_size_next;
    logic [cu_pkg::CHOOSE_W-1:0]   choose_reg, choose_next;
    logic                          out_valid_reg, out_valid_next;
    cu_pkg::cu_result_t            out_word_reg;
    cu_pkg::cu_cfg_t               cfg;
    cu_pkg::cu_result_t            result;
    logic                          push;
    logic                          step_en;

    // Register write decode.
    always_comb
    begin
        set_size_next = set_size_reg;
        choose_next   = choose_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cu_pkg::REG_SET_SIZE:
                begin
                    set_size_next = cfg_data[cu_pkg::SET_SIZE_W-1:0];
                end
                cu_pkg::REG_CHOOSE_COUNT:
                begin
                    choose_next = cfg_data[cu_pkg::CHOOSE_W-1:0];
                end
                default:
                begin
                    set_size_next = set_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= cu_pkg::SET_SIZE_RESET;
            choose_reg   <= cu_pkg::CHOOSE_RESET;
        end
        else
        begin
            set_size_reg <= set_size_next;
            choose_reg   <= choose_next;
        end
    end

    assign cfg = '{set_size: set_size_reg, choose_count: choose_reg};

    // The walk advances only when the output register can take a word.
    assign step_en = !out_valid_reg || out_ready;

    cu_walker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_CHOOSE   (MAX_CHOOSE)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rank     (rank),
        .step_en  (step_en),
        .push     (push),
        .result   (result)
    );

    // Output register.
    assign out_valid_next = push || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = out_word_reg.position;
    assign last         = out_word_reg.last;
    assign out_of_range = out_word_reg.out_of_range;

    // Checks on the walker and output register.
    `ASSERT_IMPLIES(a_push_needs_room, clk, rst_n, push, step_en, "word pushed into a full output register")
    `ASSERT_IMPLIES(a_reject_is_single, clk, rst_n, out_valid && out_of_range, last && (position == '0), "out-of-range word not final or not zero")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "rank accepted while a walk is under way")

endmodule
